### sv/knn_pkg.sv
package knn_pkg;

    localparam int COORD_W    = 16;
    localparam int SQ_W       = 32;
    localparam int DIST_W     = 33;
    localparam int RANK_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_QUERY_X         = 2'd0,
        REG_QUERY_Y         = 2'd1,
        REG_QUERY_INDEX     = 2'd2,
        REG_NEIGHBOUR_COUNT = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic last;
        logic skip;
    } item_flags_t;

    typedef struct packed {
        logic                  empty;
        logic [FIFO_CNT_W-1:0] count;
    } fifo_status_t;

endpackage

### sv/knn_front.sv
module knn_front #(
    parameter int MAX_NEIGHBOURS = 16,
    parameter int INDEX_BITS     = 20,
    localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1),
    localparam int ITEM_W = knn_pkg::DIST_W + INDEX_BITS + 2 * knn_pkg::COORD_W
                            + $bits(knn_pkg::item_flags_t)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [knn_pkg::COORD_W-1:0]  point_x,
    input  logic signed [knn_pkg::COORD_W-1:0]  point_y,
    input  logic [INDEX_BITS-1:0]               point_index,
    input  logic                                last_point,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [knn_pkg::CFG_ADDR_W-1:0]      cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  knn_pkg::fifo_status_t               fifo_st,
    output logic                                fifo_push,
    output logic [ITEM_W-1:0]                   fifo_data,
    output logic [CNT_W-1:0]                    cap
);
    import knn_pkg::*;

    logic signed [COORD_W-1:0] query_x_reg;
    logic signed [COORD_W-1:0] query_y_reg;
    logic [INDEX_BITS-1:0]     query_index_reg;
    logic [COUNT_W-1:0]        count_reg;

    logic                      accept;
    logic [FIFO_CNT_W:0]       occupancy;

    logic                      a_valid_reg;
    logic signed [COORD_W:0]   a_dx_reg;
    logic signed [COORD_W:0]   a_dy_reg;
    logic signed [COORD_W-1:0] a_x_reg;
    logic signed [COORD_W-1:0] a_y_reg;
    logic [INDEX_BITS-1:0]     a_idx_reg;
    item_flags_t               a_flags_reg;

    logic                      b_valid_reg;
    logic [SQ_W-1:0]           b_sx_reg;
    logic [SQ_W-1:0]           b_sy_reg;
    logic signed [COORD_W-1:0] b_x_reg;
    logic signed [COORD_W-1:0] b_y_reg;
    logic [INDEX_BITS-1:0]     b_idx_reg;
    item_flags_t               b_flags_reg;

    logic signed [2*COORD_W+1:0] sq_x;
    logic signed [2*COORD_W+1:0] sq_y;
    logic [DIST_W-1:0]           sq_dist;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        occupancy = {1'b0, fifo_st.count} + (FIFO_CNT_W + 1)'(a_valid_reg)
                    + (FIFO_CNT_W + 1)'(b_valid_reg);
        full      = occupancy >= (FIFO_CNT_W + 1)'(FIFO_DEPTH);
        accept    = push && !full;
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            cap = CNT_W'(1);
        end
        else if (32'(count_reg) > 32'(MAX_NEIGHBOURS))
        begin
            cap = CNT_W'(MAX_NEIGHBOURS);
        end
        else
        begin
            cap = CNT_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_x_reg     <= '0;
            query_y_reg     <= '0;
            query_index_reg <= '0;
            count_reg       <= COUNT_RESET;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_QUERY_X:         query_x_reg     <= cfg_data[COORD_W-1:0];
                    REG_QUERY_Y:         query_y_reg     <= cfg_data[COORD_W-1:0];
                    REG_QUERY_INDEX:     query_index_reg <= cfg_data[INDEX_BITS-1:0];
                    REG_NEIGHBOUR_COUNT: count_reg       <= cfg_data[COUNT_W-1:0];
                    default:             count_reg       <= count_reg;
                endcase
            end
        end
    end

    assign sq_x = a_dx_reg * a_dx_reg;
    assign sq_y = a_dy_reg * a_dy_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_dx_reg         <= {query_x_reg[COORD_W-1], query_x_reg}
                                - {point_x[COORD_W-1], point_x};
            a_dy_reg         <= {query_y_reg[COORD_W-1], query_y_reg}
                                - {point_y[COORD_W-1], point_y};
            a_x_reg          <= point_x;
            a_y_reg          <= point_y;
            a_idx_reg        <= point_index;
            a_flags_reg.last <= last_point;
            a_flags_reg.skip <= point_index == query_index_reg;
        end
        b_sx_reg    <= sq_x[SQ_W-1:0];
        b_sy_reg    <= sq_y[SQ_W-1:0];
        b_x_reg     <= a_x_reg;
        b_y_reg     <= a_y_reg;
        b_idx_reg   <= a_idx_reg;
        b_flags_reg <= a_flags_reg;
    end

    assign sq_dist   = {1'b0, b_sx_reg} + {1'b0, b_sy_reg};
    assign fifo_push = b_valid_reg;
    assign fifo_data = {sq_dist, b_idx_reg, b_x_reg, b_y_reg, b_flags_reg};

endmodule

### sv/knn_fifo.sv
module knn_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      wdata,
    input  logic                  pop,
    output logic [WIDTH-1:0]      rdata,
    output knn_pkg::fifo_status_t status
);
    import knn_pkg::*;

    logic [WIDTH-1:0]      mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign status.empty = count_reg == '0;
    assign status.count = count_reg;
    assign rdata        = mem_reg[rd_ptr_reg];
    assign do_push      = push && (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign do_pop       = pop && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/knn_back.sv
module knn_back #(
    parameter int MAX_NEIGHBOURS = 16,
    parameter int INDEX_BITS     = 20,
    localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1),
    localparam int IDX_W  = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1,
    localparam int ITEM_W = knn_pkg::DIST_W + INDEX_BITS + 2 * knn_pkg::COORD_W
                            + $bits(knn_pkg::item_flags_t)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  knn_pkg::fifo_status_t               fifo_st,
    input  logic [ITEM_W-1:0]                   fifo_data,
    output logic                                fifo_pop,
    input  logic [CNT_W-1:0]                    cap,
    output logic                                empty,
    input  logic                                pop,
    output logic [INDEX_BITS-1:0]               neighbour_index,
    output logic signed [knn_pkg::COORD_W-1:0]  neighbour_x,
    output logic signed [knn_pkg::COORD_W-1:0]  neighbour_y,
    output logic [knn_pkg::DIST_W-1:0]          squared_distance,
    output logic [knn_pkg::RANK_W-1:0]          rank,
    output logic                                found,
    output logic                                last_result
);
    import knn_pkg::*;

    typedef struct packed {
        logic [DIST_W-1:0]         sq_dist;
        logic [INDEX_BITS-1:0]     idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } entry_t;

    entry_t              head;
    item_flags_t         head_flags;

    entry_t              list_reg  [MAX_NEIGHBOURS];
    entry_t              list_next [MAX_NEIGHBOURS];
    entry_t              snap_reg  [MAX_NEIGHBOURS];
    logic [CNT_W-1:0]    held_reg;
    logic [CNT_W-1:0]    held_eff;
    logic [CNT_W-1:0]    held_ins;
    logic [CNT_W-1:0]    cap_last;
    logic [MAX_NEIGHBOURS-1:0] ahead;
    logic [MAX_NEIGHBOURS-1:0] prev;
    logic                insert;
    logic                take;

    logic                snap_busy_reg;
    logic [CNT_W-1:0]    snap_left_reg;
    logic [RANK_W-1:0]   snap_rank_reg;
    logic                emit;

    logic                out_valid_reg;
    entry_t              out_entry_reg;
    logic [RANK_W-1:0]   out_rank_reg;
    logic                out_found_reg;
    logic                out_last_reg;

    assign {head, head_flags} = fifo_data;

    assign take     = !fifo_st.empty && (!head_flags.last || !snap_busy_reg);
    assign fifo_pop = take;

    always_comb
    begin
        held_eff = (held_reg > cap) ? cap : held_reg;
        for (int i = 0; i < MAX_NEIGHBOURS; i++)
        begin
            ahead[i] = (CNT_W'(i) < held_eff)
                       && ((list_reg[i].sq_dist < head.sq_dist)
                           || ((list_reg[i].sq_dist == head.sq_dist)
                               && (list_reg[i].idx <= head.idx)));
        end
        prev[0] = 1'b1;
        for (int i = 1; i < MAX_NEIGHBOURS; i++)
        begin
            prev[i] = ahead[i-1];
        end
        cap_last = cap - 1'b1;
        insert   = !head_flags.skip && !ahead[cap_last[IDX_W-1:0]];

        for (int i = 0; i < MAX_NEIGHBOURS; i++)
        begin
            list_next[i] = list_reg[i];
        end
        if (insert)
        begin
            for (int i = 0; i < MAX_NEIGHBOURS; i++)
            begin
                if (!ahead[i] && prev[i])
                begin
                    list_next[i] = head;
                end
            end
            for (int i = 1; i < MAX_NEIGHBOURS; i++)
            begin
                if (!ahead[i] && !prev[i])
                begin
                    list_next[i] = list_reg[i-1];
                end
            end
        end

        held_ins = held_eff;
        if (insert && (held_eff < cap))
        begin
            held_ins = held_eff + 1'b1;
        end
    end

    assign emit = snap_busy_reg && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            snap_busy_reg <= 1'b0;
            snap_left_reg <= '0;
            snap_rank_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                if (head_flags.last)
                begin
                    held_reg      <= '0;
                    snap_busy_reg <= 1'b1;
                    snap_left_reg <= held_ins;
                    snap_rank_reg <= '0;
                end
                else if (!head_flags.skip)
                begin
                    held_reg <= held_ins;
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                snap_rank_reg <= snap_rank_reg + 1'b1;
                if (snap_left_reg <= CNT_W'(1))
                begin
                    snap_busy_reg <= 1'b0;
                    snap_left_reg <= '0;
                end
                else
                begin
                    snap_left_reg <= snap_left_reg - 1'b1;
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < MAX_NEIGHBOURS; i++)
            begin
                list_reg[i] <= list_next[i];
            end
        end
        if (take && head_flags.last)
        begin
            for (int i = 0; i < MAX_NEIGHBOURS; i++)
            begin
                snap_reg[i] <= list_next[i];
            end
        end
        else if (emit)
        begin
            for (int i = 0; i < MAX_NEIGHBOURS - 1; i++)
            begin
                snap_reg[i] <= snap_reg[i+1];
            end
        end
        if (emit)
        begin
            out_entry_reg <= (snap_left_reg != '0) ? snap_reg[0] : '0;
            out_rank_reg  <= snap_rank_reg;
            out_found_reg <= snap_left_reg != '0;
            out_last_reg  <= snap_left_reg <= CNT_W'(1);
        end
    end

    assign empty            = !out_valid_reg;
    assign neighbour_index  = out_entry_reg.idx;
    assign neighbour_x      = out_entry_reg.x;
    assign neighbour_y      = out_entry_reg.y;
    assign squared_distance = out_entry_reg.sq_dist;
    assign rank             = out_rank_reg;
    assign found            = out_found_reg;
    assign last_result      = out_last_reg;

endmodule

### sv/k_nearest_neighbour_select.sv
// Throughput: one candidate per cycle while full is low; results leave one per cycle
// while pop is high. A candidate passes the difference and square registers and the queue
// before it enters the sorted list; a run's results leave from a registered snapshot of it.
// A last candidate waits in the 4-entry queue while the previous run still drains.
// Reset (async, active low) empties the list and queues and loads register defaults.
module k_nearest_neighbour_select #(
    parameter int MAX_NEIGHBOURS = 16,
    parameter int INDEX_BITS     = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [knn_pkg::COORD_W-1:0]  point_x,
    input  logic signed [knn_pkg::COORD_W-1:0]  point_y,
    input  logic [INDEX_BITS-1:0]               point_index,
    input  logic                                last_point,
    output logic                                empty,
    input  logic                                pop,
    output logic [INDEX_BITS-1:0]               neighbour_index,
    output logic signed [knn_pkg::COORD_W-1:0]  neighbour_x,
    output logic signed [knn_pkg::COORD_W-1:0]  neighbour_y,
    output logic [knn_pkg::DIST_W-1:0]          squared_distance,
    output logic [knn_pkg::RANK_W-1:0]          rank,
    output logic                                found,
    output logic                                last_result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [knn_pkg::CFG_ADDR_W-1:0]      cfg_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import knn_pkg::*;

    localparam int CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
    localparam int ITEM_W = DIST_W + INDEX_BITS + 2 * COORD_W + $bits(item_flags_t);

    fifo_status_t      fifo_st;
    logic              fifo_push;
    logic              fifo_pop;
    logic [ITEM_W-1:0] fifo_wdata;
    logic [ITEM_W-1:0] fifo_rdata;
    logic [CNT_W-1:0]  cap;

    knn_front #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
        .INDEX_BITS     (INDEX_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index),
        .last_point  (last_point),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fifo_st     (fifo_st),
        .fifo_push   (fifo_push),
        .fifo_data   (fifo_wdata),
        .cap         (cap)
    );

    knn_fifo #(
        .WIDTH (ITEM_W)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (fifo_push),
        .wdata  (fifo_wdata),
        .pop    (fifo_pop),
        .rdata  (fifo_rdata),
        .status (fifo_st)
    );

    knn_back #(
        .MAX_NEIGHBOURS (MAX_NEIGHBOURS),
        .INDEX_BITS     (INDEX_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .fifo_st          (fifo_st),
        .fifo_data        (fifo_rdata),
        .fifo_pop         (fifo_pop),
        .cap              (cap),
        .empty            (empty),
        .pop              (pop),
        .neighbour_index  (neighbour_index),
        .neighbour_x      (neighbour_x),
        .neighbour_y      (neighbour_y),
        .squared_distance (squared_distance),
        .rank             (rank),
        .found            (found),
        .last_result      (last_result)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> (fifo_st.count < FIFO_CNT_W'(FIFO_DEPTH)))
        else $error("request queue overrun");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !found) |-> (last_result && (rank == '0)))
        else $error("empty-run result not alone");

    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_pop |-> !fifo_st.empty)
        else $error("pop from empty request queue");

endmodule
